// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the heading block checkers.
// The enclosing module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under the block clock, off while in reset.
`define MHC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define MHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mhc_pkg.sv =====
`default_nettype none

package mhc_pkg;

	// calibration length in samples (2..4096)
	localparam int CAL_SAMPLES = 256;
	localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);

	localparam int SAMP_W       = 16;
	localparam int AXIS_W       = 17;
	localparam int ANGLE_W      = 18;
	localparam int SEL_W        = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = 4;
	localparam int PRESCALE     = 15;
	localparam int CORDIC_W     = 35;
	localparam int ATAN_W       = 14;
	localparam int NUM_AXES     = 3;

	localparam logic signed [ANGLE_W-1:0] ANGLE_PI      = 18'sd32768;
	localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 18'sd16384;

	// register indexes of the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_AXIS = 2'd0,
		REG_DEN_AXIS = 2'd1,
		REG_HEAD_OFS = 2'd2
	} cfg_reg_t;

	localparam logic [SEL_W-1:0] NUM_AXIS_RST = 3'd2;
	localparam logic [SEL_W-1:0] DEN_AXIS_RST = 3'd1;

	// axis selector magnitudes
	localparam logic [SEL_W-1:0] AXIS_X = 3'd1;
	localparam logic [SEL_W-1:0] AXIS_Y = 3'd2;
	localparam logic [SEL_W-1:0] AXIS_Z = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SELECT,
		ST_ROTATE,
		ST_WAIT_OUT
	} mhc_state_t;

	typedef struct packed {
		logic                       start;
		logic signed [AXIS_W-1:0]   y;
		logic signed [AXIS_W-1:0]   x;
	} cordic_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [ANGLE_W-1:0]  angle;
	} cordic_rsp_t;

	// round(atan(2^-i) * 32768 / pi)
	function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
		logic [ATAN_W-1:0] t;
		case (idx)
			4'd0:    t = 14'd8192;
			4'd1:    t = 14'd4836;
			4'd2:    t = 14'd2555;
			4'd3:    t = 14'd1297;
			4'd4:    t = 14'd651;
			4'd5:    t = 14'd326;
			4'd6:    t = 14'd163;
			4'd7:    t = 14'd81;
			4'd8:    t = 14'd41;
			4'd9:    t = 14'd20;
			4'd10:   t = 14'd10;
			4'd11:   t = 14'd5;
			4'd12:   t = 14'd3;
			4'd13:   t = 14'd1;
			4'd14:   t = 14'd1;
			default: t = 14'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mhc_intf.sv =====
`default_nettype none

// sample request channel
interface mhc_in_if;
	import mhc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [SAMP_W-1:0]  mag_x;
	logic signed [SAMP_W-1:0]  mag_y;
	logic signed [SAMP_W-1:0]  mag_z;

	modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
	modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

// heading result channel
interface mhc_out_if;
	import mhc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] heading;
	logic                      calibrating;

	modport source (output valid, output heading, output calibrating, input ready);
	modport sink   (input valid, input heading, input calibrating, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mhc_cordic.sv =====
`default_nettype none

// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
module mhc_cordic import mhc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cordic_req_t req,
	output cordic_rsp_t      rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic signed [CORDIC_W-1:0]  x_q;
	logic signed [CORDIC_W-1:0]  y_q;
	logic signed [ANGLE_W-1:0]   z_q;

	logic signed [CORDIC_W-1:0]  x_ext;
	logic signed [CORDIC_W-1:0]  y_ext;
	logic signed [CORDIC_W-1:0]  x_pre;
	logic signed [CORDIC_W-1:0]  y_pre;
	logic signed [CORDIC_W-1:0]  xs;
	logic signed [CORDIC_W-1:0]  ys;
	logic signed [ANGLE_W-1:0]   t_ang;
	logic                        rot_pos;
	logic                        special;
	logic                        last_step;

	always_comb begin
		x_ext     = {{(CORDIC_W-AXIS_W){req.x[AXIS_W-1]}}, req.x};
		y_ext     = {{(CORDIC_W-AXIS_W){req.y[AXIS_W-1]}}, req.y};
		x_pre     = x_ext <<< PRESCALE;
		y_pre     = y_ext <<< PRESCALE;
		special   = (req.y == '0) || (req.x == '0);
		xs        = x_q >>> step_q;
		ys        = y_q >>> step_q;
		rot_pos   = !y_q[CORDIC_W-1] && (y_q != '0);
		t_ang     = ANGLE_W'(atan_lut(step_q));
		last_step = (step_q == STEP_W'(CORDIC_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= (busy_q && last_step) || (req.start && special);
			if (req.start) begin
				busy_q <= !special;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.y == '0) begin
				z_q <= req.x[AXIS_W-1] ? ANGLE_PI : '0;
			end else if (req.x == '0) begin
				z_q <= req.y[AXIS_W-1] ? -ANGLE_HALF_PI : ANGLE_HALF_PI;
			end else if (req.x[AXIS_W-1]) begin
				// left half plane: fold by pi
				x_q <= -x_pre;
				y_q <= -y_pre;
				z_q <= req.y[AXIS_W-1] ? -ANGLE_PI : ANGLE_PI;
			end else begin
				x_q <= x_pre;
				y_q <= y_pre;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (rot_pos) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + t_ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - t_ang;
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (z_q > ANGLE_PI) begin
			rsp.angle = ANGLE_PI;
		end else if (z_q < -ANGLE_PI) begin
			rsp.angle = -ANGLE_PI;
		end else begin
			rsp.angle = z_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/magnetometer_heading_with_calibration.sv =====
// Magnetometer heading with hard-iron min/max calibration.
//
// samp:   request channel, one raw signed 16-bit x/y/z sample per request,
//         taken at a clock edge with valid and ready high.
// result: one heading per sample (18-bit signed, pi = 32768) and the
//         calibrating flag, held in an output register until taken.
// cfg:    write-only port; cfg_we with cfg_index selects numerator axis,
//         denominator axis or heading offset. Writes to index 3 are dropped.
//
// Timing: a sample is folded into min/max (or latches the offsets) at the
// accept edge, axes are selected the next cycle, then a single shared
// CORDIC stage runs 16 micro-rotations (none when an operand is zero)
// and the angle is loaded into the output register. samp.ready returns
// in the same cycle that result.valid rises, so a new sample is not taken
// until the previous one is through the CORDIC.
// If result is stalled, the finished angle waits in the CORDIC and samp
// stays low until the output register frees up.
// Reset clears counters, min/max/offsets and loads register defaults
// (numerator y, denominator x, offset 0).
`default_nettype none

module magnetometer_heading_with_calibration import mhc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	mhc_in_if.sink                       samp,
	mhc_out_if.source                    result
);

	localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);
	localparam logic [CNT_W-1:0] CAL_FULL = CNT_W'(CAL_SAMPLES);

	// axis value: sample minus offset, negated for negative selector,
	// constant -1 for a meaningless selector
	function automatic logic signed [AXIS_W-1:0] select_axis(
		input logic [SEL_W-1:0]        sel,
		input logic signed [SAMP_W-1:0] sx,
		input logic signed [SAMP_W-1:0] sy,
		input logic signed [SAMP_W-1:0] sz,
		input logic signed [SAMP_W-1:0] ox,
		input logic signed [SAMP_W-1:0] oy,
		input logic signed [SAMP_W-1:0] oz
	);
		logic [SEL_W-1:0]         mag;
		logic signed [AXIS_W-1:0] v;
		mag = sel[SEL_W-1] ? (~sel + 1'b1) : sel;
		case (mag)
			AXIS_X:  v = {sx[SAMP_W-1], sx} - {ox[SAMP_W-1], ox};
			AXIS_Y:  v = {sy[SAMP_W-1], sy} - {oy[SAMP_W-1], oy};
			AXIS_Z:  v = {sz[SAMP_W-1], sz} - {oz[SAMP_W-1], oz};
			default: v = '1;
		endcase
		if (sel[SEL_W-1] && (mag == AXIS_X || mag == AXIS_Y || mag == AXIS_Z)) begin
			v = -v;
		end
		return v;
	endfunction

	mhc_state_t state_q, state_d;

	logic [SEL_W-1:0]          num_axis_q;
	logic [SEL_W-1:0]          den_axis_q;
	logic [CFG_DATA_W-1:0]     head_ofs_q;

	logic [CNT_W-1:0]          cnt_q;
	logic signed [SAMP_W-1:0]  max_q [NUM_AXES];
	logic signed [SAMP_W-1:0]  min_q [NUM_AXES];
	logic signed [SAMP_W-1:0]  ofs_q [NUM_AXES];
	logic signed [SAMP_W-1:0]  smp_q [NUM_AXES];
	logic signed [SAMP_W-1:0]  smp_in [NUM_AXES];
	logic signed [SAMP_W-1:0]  mid [NUM_AXES];

	logic                      res_valid_q;
	logic signed [ANGLE_W-1:0] heading_q;
	logic                      calib_q;

	logic                      accept;
	logic                      out_free;
	logic                      load_out;
	logic                      in_ready;
	logic                      start_rot;
	logic signed [ANGLE_W-1:0] head_next;

	cordic_req_t               creq;
	cordic_rsp_t               crsp;

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_axis_q <= NUM_AXIS_RST;
			den_axis_q <= DEN_AXIS_RST;
			head_ofs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_AXIS: num_axis_q <= cfg_data[SEL_W-1:0];
				REG_DEN_AXIS: den_axis_q <= cfg_data[SEL_W-1:0];
				REG_HEAD_OFS: head_ofs_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// ---------------- calibration ----------------
	assign accept    = samp.valid && in_ready;
	assign smp_in[0] = samp.mag_x;
	assign smp_in[1] = samp.mag_y;
	assign smp_in[2] = samp.mag_z;

	// truncating midpoint: add one to a negative sum before the halving shift
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			logic signed [SAMP_W:0] sum;
			logic signed [SAMP_W:0] adj;
			sum    = {max_q[i][SAMP_W-1], max_q[i]} + {min_q[i][SAMP_W-1], min_q[i]};
			adj    = sum + (SAMP_W+1)'(sum[SAMP_W]);
			mid[i] = adj[SAMP_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				max_q[i] <= '0;
				min_q[i] <= '0;
				ofs_q[i] <= '0;
			end
		end else if (accept) begin
			if (cnt_q == '0) begin
				// first sample seeds the range
				for (int i = 0; i < NUM_AXES; i++) begin
					max_q[i] <= smp_in[i];
					min_q[i] <= smp_in[i];
				end
				cnt_q <= cnt_q + 1'b1;
			end else if (cnt_q < CAL_LAST) begin
				for (int i = 0; i < NUM_AXES; i++) begin
					if (smp_in[i] > max_q[i]) begin
						max_q[i] <= smp_in[i];
					end
					if (smp_in[i] < min_q[i]) begin
						min_q[i] <= smp_in[i];
					end
				end
				cnt_q <= cnt_q + 1'b1;
			end else begin
				// latch sample and beyond: offsets from the frozen range
				for (int i = 0; i < NUM_AXES; i++) begin
					ofs_q[i] <= mid[i];
				end
				if (cnt_q < CAL_FULL) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				smp_q[i] <= smp_in[i];
			end
		end
	end

	// ---------------- sequencer ----------------
	assign out_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (samp.valid) state_d = ST_SELECT;
			ST_SELECT:   state_d = ST_ROTATE;
			ST_ROTATE:   if (crsp.done) state_d = out_free ? ST_IDLE : ST_WAIT_OUT;
			ST_WAIT_OUT: if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		start_rot = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE:     in_ready  = 1'b1;
			ST_SELECT:   start_rot = 1'b1;
			ST_ROTATE:   load_out  = crsp.done && out_free;
			ST_WAIT_OUT: load_out  = out_free;
			default:     ;
		endcase
	end

	assign samp.ready = in_ready;

	// operands use the offsets already updated by this sample
	always_comb begin
		creq.start = start_rot;
		creq.y     = select_axis(num_axis_q, smp_q[0], smp_q[1], smp_q[2],
			ofs_q[0], ofs_q[1], ofs_q[2]);
		creq.x     = select_axis(den_axis_q, smp_q[0], smp_q[1], smp_q[2],
			ofs_q[0], ofs_q[1], ofs_q[2]);
	end

	mhc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	// ---------------- output register ----------------
	assign head_next = crsp.angle - {{(ANGLE_W-CFG_DATA_W){head_ofs_q[CFG_DATA_W-1]}}, head_ofs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			heading_q <= head_next;
			calib_q   <= (cnt_q < CAL_FULL);
		end
	end

	assign result.valid       = res_valid_q;
	assign result.heading     = heading_q;
	assign result.calibrating = calib_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mhc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module mhc_checker import mhc_pkg::*; (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      samp_valid,
	input wire logic                      samp_ready,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic signed [ANGLE_W-1:0] heading,
	input wire logic                      calibrating
);

	// block stays busy for at least the select state and the first rotate state
	`MHC_ASSERT_NEXT(a_busy_after_req, samp_valid && samp_ready, !samp_ready ##1 !samp_ready, "sample taken while busy")

	// heading bounded by clamp range minus offset range
	`MHC_ASSERT(a_heading_range, res_valid |-> (heading >= -18'sd65535 && heading <= 18'sd65536), "heading out of range")

	// once offsets latch, calibration never restarts
	`MHC_ASSERT_NEXT(a_calib_sticky, res_valid && !calibrating, !calibrating, "calibrating reasserted")

	// stalled result holds
	`MHC_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(heading), "stalled result changed")

endmodule

bind magnetometer_heading_with_calibration mhc_checker u_mhc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.samp_valid  (samp.valid),
	.samp_ready  (samp.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.heading     (result.heading),
	.calibrating (result.calibrating)
);

`default_nettype wire
